>>> sv/wbpc_pkg.sv
// ----------------------------------------------------------------------------
// Walker branching package
// Shared types, codes and constants of the walker branching control unit.
// ----------------------------------------------------------------------------
`default_nettype none

package wbpc_pkg;

  localparam int CW = 7;

  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_WALK = 2'd1;
  localparam logic [1:0] FUNC_GEN  = 2'd2;

  localparam logic [1:0] KIND_VERDICT = 2'd0;
  localparam logic [1:0] KIND_COPY    = 2'd1;
  localparam logic [1:0] KIND_MOVE    = 2'd2;
  localparam logic [1:0] KIND_DONE    = 2'd3;

  localparam logic [1:0] REG_TIME_STEP = 2'd0;
  localparam logic [1:0] REG_TRIAL     = 2'd1;
  localparam logic [1:0] REG_HALFWIDTH = 2'd2;
  localparam logic [1:0] REG_CAPACITY  = 2'd3;

  localparam logic [15:0] RST_TIME_STEP = 16'd655;
  localparam logic [30:0] RST_HALFWIDTH = 31'd1310720;
  localparam logic [6:0]  RST_CAPACITY  = 7'd64;

  localparam logic [17:0] LOG2E_Q16  = 18'd94548;
  localparam logic [12:0] EXP_C3     = 13'd5084;
  localparam logic [14:0] EXP_C2     = 15'd14838;
  localparam logic [15:0] EXP_C1     = 16'd45611;
  localparam logic [16:0] EXP_C0     = 17'd65536;
  localparam logic [21:0] WEIGHT_CAP = 22'd655360;

  localparam logic signed [20:0] Y_LO = -21'sd1048576;
  localparam logic signed [20:0] Y_HI = 21'sd262144;

  localparam logic [3:0] CALC_LAST = 4'd8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_VERDICT,
    S_COPY,
    S_SCAN,
    S_MOVE,
    S_COUNT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic do_load;
    logic verdict;
    logic copy;
    logic move;
    logic gen_done;
    logic last;
    logic rd_j;
    logic cmp_init;
    logic inc_i;
    logic dec_j;
    logic cnt_init;
    logic cnt_step;
  } cmd_t;

  typedef struct packed {
    logic [1:0]    func;
    logic          walk_ok;
    logic          out_free;
    logic [CW-1:0] ncopy;
    logic          i_lt_j;
    logic          alive_i;
    logic          alive_j;
    logic          i_ge_cap;
  } sts_t;

endpackage

`default_nettype wire

>>> sv/wbpc_if.sv
// ----------------------------------------------------------------------------
// Walker branching channels
// Input and result channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface wbpc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [5:0]         slot;
  logic signed [31:0] energy;
  logic [15:0]        uniform;

  modport source(output valid, output func, output slot, output energy, output uniform,
                 input ready);
  modport sink(input valid, input func, input slot, input energy, input uniform,
               output ready);
endinterface

interface wbpc_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [5:0]         source_slot;
  logic [5:0]         dest_slot;
  logic signed [31:0] clamped_energy;
  logic [19:0]        weight;
  logic signed [35:0] weighted_energy;
  logic [3:0]         offspring;
  logic [6:0]         population;
  logic               last;

  modport source(output valid, output kind, output source_slot, output dest_slot,
                 output clamped_energy, output weight, output weighted_energy,
                 output offspring, output population, output last, input ready);
  modport sink(input valid, input kind, input source_slot, input dest_slot,
               input clamped_energy, input weight, input weighted_energy,
               input offspring, input population, input last, output ready);
endinterface

`default_nettype wire

>>> sv/walker_branching_population_control_unit.sv
// ----------------------------------------------------------------------------
// Walker branching population control unit
// Loads write the slot store; a walker verdict beat follows acceptance
// after a weight pipeline of 9 registered steps, then one copy beat per copy
// before the next item is taken. End of generation: scan steps, moves, live
// counting over the capacity, then the done beat.
// One item at a time; synchronous active-low reset clears all slots' alive
// marks, counts, reference energy and restores register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module walker_branching_population_control_unit #(
  parameter int MAX_SLOTS     = 64,
  parameter int MAX_OFFSPRING = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  wbpc_in_if.sink          in_ch,
  wbpc_out_if.source       out_ch
);
  import wbpc_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign in_ch.ready = in_ready;

  wbpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wbpc_dp #(
    .MAX_SLOTS     (MAX_SLOTS),
    .MAX_OFFSPRING (MAX_OFFSPRING)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_func    (in_ch.func),
    .in_slot    (in_ch.slot),
    .in_energy  (in_ch.energy),
    .in_uniform (in_ch.uniform),
    .cmd        (cmd),
    .sts        (sts),
    .out_ch     (out_ch)
  );

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.verdict || cmd.copy || cmd.move || cmd.gen_done) |-> sts.out_free)
    else $error("result beat issued while result register busy");

  a_emit_one: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.verdict, cmd.copy, cmd.move, cmd.gen_done}))
    else $error("more than one result beat issued");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !(cmd.verdict || cmd.copy || cmd.move || cmd.gen_done))
    else $error("result beat issued while accepting input");

  a_move_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.move |-> (sts.i_lt_j && sts.alive_j && !sts.alive_i))
    else $error("move without hole ahead of live slot");

endmodule

`default_nettype wire

>>> sv/wbpc_ctrl.sv
// ----------------------------------------------------------------------------
// Walker branching controller
// Sequences load, walker, copy, compaction and count steps of the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module wbpc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire wbpc_pkg::sts_t sts,
  output wbpc_pkg::cmd_t     cmd
);
  import wbpc_pkg::*;

  state_t        state_r, state_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  logic [CW-1:0] left_r, left_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      left_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      left_r  <= left_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    left_nxt  = left_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cnt_nxt  = '0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (sts.func)
            FUNC_LOAD: cmd.do_load = 1'b1;
            FUNC_WALK: if (sts.walk_ok) state_nxt = S_CALC;
            FUNC_GEN: begin
              cmd.cmp_init = 1'b1;
              state_nxt    = S_SCAN;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_CALC: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == CALC_LAST) state_nxt = S_VERDICT;
      end
      S_VERDICT: begin
        if (sts.out_free) begin
          cmd.verdict = 1'b1;
          cmd.last    = (sts.ncopy == '0);
          left_nxt    = sts.ncopy;
          state_nxt   = (sts.ncopy == '0) ? S_IDLE : S_COPY;
        end
      end
      S_COPY: begin
        if (sts.out_free) begin
          cmd.copy = 1'b1;
          cmd.last = (left_r == CW'(1));
          left_nxt = left_r - CW'(1);
          if (left_r == CW'(1)) state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.rd_j = 1'b1;
        if (!sts.i_lt_j) begin
          cmd.cnt_init = 1'b1;
          state_nxt    = S_COUNT;
        end else if (sts.alive_i) begin
          cmd.inc_i = 1'b1;
        end else if (!sts.alive_j) begin
          cmd.dec_j = 1'b1;
        end else begin
          state_nxt = S_MOVE;
        end
      end
      S_MOVE: begin
        cmd.rd_j = 1'b1;
        if (sts.out_free) begin
          cmd.move  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_COUNT: begin
        if (sts.i_ge_cap) state_nxt = S_DONE;
        else cmd.cnt_step = 1'b1;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.gen_done = 1'b1;
          cmd.last     = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/wbpc_dp.sv
// ----------------------------------------------------------------------------
// Walker branching datapath
// Configuration, slot store, weight pipeline, pointers and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wbpc_dp #(
  parameter int MAX_SLOTS     = 64,
  parameter int MAX_OFFSPRING = 10
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic [1:0]         in_func,
  input  wire logic [5:0]         in_slot,
  input  wire logic signed [31:0] in_energy,
  input  wire logic [15:0]        in_uniform,
  input  wire wbpc_pkg::cmd_t     cmd,
  output wbpc_pkg::sts_t          sts,
  wbpc_out_if.source              out_ch
);
  import wbpc_pkg::*;

  localparam int IW     = (MAX_SLOTS > 2) ? $clog2(MAX_SLOTS) : 1;
  localparam int CAPMAX = (MAX_SLOTS > 127) ? 127 : MAX_SLOTS;

  logic [15:0]        ts_r;
  logic signed [31:0] trial_r;
  logic [30:0]        half_r;
  logic [CW-1:0]      capreg_r;
  logic [CW-1:0]      cap;

  logic [CW-1:0]      pop_r, copy_r, cnt_r, i_r, j_r;
  logic signed [31:0] ref_r;
  logic [MAX_SLOTS-1:0] alive_r;

  logic [5:0]         slot_r;
  logic signed [31:0] energy_r;
  logic [15:0]        uni_r;

  logic signed [31:0] mem [MAX_SLOTS];
  logic signed [31:0] rdata_r;
  logic [IW-1:0]      rd_addr, wr_addr;
  logic               wr_en;
  logic signed [31:0] wr_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r     <= RST_TIME_STEP;
      trial_r  <= '0;
      half_r   <= RST_HALFWIDTH;
      capreg_r <= RST_CAPACITY;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIME_STEP: ts_r     <= cfg_data[15:0];
        REG_TRIAL:     trial_r  <= $signed(cfg_data);
        REG_HALFWIDTH: half_r   <= cfg_data[30:0];
        REG_CAPACITY:  capreg_r <= cfg_data[6:0];
        default:       ts_r     <= ts_r;
      endcase
    end
  end

  assign cap = (capreg_r > CW'(CAPMAX)) ? CW'(CAPMAX) : capreg_r;

  // weight pipeline, free running on held operands
  logic signed [33:0] d_r, arg_r;
  logic signed [50:0] prod;
  logic signed [34:0] neg;
  logic signed [20:0] y;
  logic signed [38:0] ty;
  logic signed [22:0] t_r;
  logic [15:0]        f;
  logic [6:0]         nn;
  logic [28:0]        q1;
  logic [30:0]        q2;
  logic [31:0]        q3;
  logic [14:0]        p1_r;
  logic [15:0]        p2_r;
  logic [16:0]        m_r;
  logic [21:0]        w_nxt, w_r;
  logic [22:0]        wsum;
  logic [6:0]         offs_raw, offs_nxt, offs_r;
  logic [19:0]        wcap_nxt, wcap_r;
  logic signed [52:0] wep;
  logic signed [35:0] we_r;

  logic signed [32:0] lo33, hi33;
  logic signed [31:0] lo, hi;
  logic signed [31:0] clamped_r;
  logic               outside_r;

  always_comb begin
    lo33 = $signed({trial_r[31], trial_r}) - $signed({2'b00, half_r});
    hi33 = $signed({trial_r[31], trial_r}) + $signed({2'b00, half_r});
    lo   = (lo33[32] != lo33[31]) ? 32'sh8000_0000 : lo33[31:0];
    hi   = (hi33[32] != hi33[31]) ? 32'sh7fff_ffff : hi33[31:0];
  end

  always_comb begin
    prod = $signed({1'b0, ts_r}) * d_r;
    neg  = -$signed({arg_r[33], arg_r});
    if (neg < Y_LO) y = Y_LO;
    else if (neg > Y_HI) y = Y_HI;
    else y = neg[20:0];
    ty = y * $signed(LOG2E_Q16);
    f  = t_r[15:0];
    nn = -t_r[22:16];
    q1 = 29'(EXP_C3) * 29'(f);
    q2 = 31'(p1_r) * 31'(f);
    q3 = 32'(p2_r) * 32'(f);
    if (t_r[22]) w_nxt = 22'(m_r >> nn);
    else w_nxt = 22'(m_r) << t_r[22:16];
    wsum     = 23'(w_r) + 23'(uni_r);
    offs_raw = wsum[22:16];
    if (outside_r) offs_nxt = '0;
    else if (offs_raw > 7'(MAX_OFFSPRING)) offs_nxt = 7'(MAX_OFFSPRING);
    else offs_nxt = offs_raw;
    wcap_nxt = (w_r > WEIGHT_CAP) ? 20'(WEIGHT_CAP) : w_r[19:0];
    wep      = $signed({1'b0, wcap_nxt}) * clamped_r;
  end

  always_ff @(posedge clk) begin
    d_r <= $signed({{2{energy_r[31]}}, energy_r}) + $signed({{2{rdata_r[31]}}, rdata_r})
           - $signed({ref_r[31], ref_r, 1'b0});
    arg_r  <= prod[50:17];
    t_r    <= ty[38:16];
    p1_r   <= EXP_C2 + 15'(q1[28:16]);
    p2_r   <= EXP_C1 + 16'(q2[30:16]);
    m_r    <= EXP_C0 + 17'(q3[31:16]);
    w_r    <= w_nxt;
    offs_r <= offs_nxt;
    wcap_r <= wcap_nxt;
    we_r   <= wep[51:16];
    if (energy_r < lo) begin
      clamped_r <= lo;
      outside_r <= 1'b1;
    end else if (energy_r > hi) begin
      clamped_r <= hi;
      outside_r <= 1'b1;
    end else begin
      clamped_r <= energy_r;
      outside_r <= 1'b0;
    end
  end

  // copy budget
  logic [CW:0]   jsum;
  logic [CW-1:0] avail, want;
  always_comb begin
    jsum  = {1'b0, pop_r} + {1'b0, copy_r};
    avail = (jsum < {1'b0, cap}) ? CW'({1'b0, cap} - jsum) : '0;
    want  = (offs_r > 7'd1) ? CW'(offs_r - 7'd1) : '0;
  end

  // slot store
  always_comb begin
    rd_addr = cmd.rd_j ? IW'(j_r) : IW'(slot_r);
    wr_en   = 1'b0;
    wr_addr = IW'(in_slot);
    wr_data = in_energy;
    if (cmd.do_load) begin
      wr_en = ({1'b0, in_slot} < cap);
    end else if (cmd.verdict) begin
      wr_en   = 1'b1;
      wr_addr = IW'(slot_r);
      wr_data = clamped_r;
    end else if (cmd.copy) begin
      wr_en   = 1'b1;
      wr_addr = IW'(j_r);
      wr_data = clamped_r;
    end else if (cmd.move) begin
      wr_en   = 1'b1;
      wr_addr = IW'(i_r);
      wr_data = rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rdata_r <= mem[rd_addr];
  end

  // capture, pointers and counters
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      slot_r   <= in_slot;
      energy_r <= in_energy;
      uni_r    <= in_uniform;
    end
    if (cmd.cmp_init) begin
      i_r <= '0;
      j_r <= (cap == '0) ? '0 : cap - CW'(1);
    end else if (cmd.inc_i) begin
      i_r <= i_r + CW'(1);
    end else if (cmd.dec_j) begin
      j_r <= j_r - CW'(1);
    end else if (cmd.move) begin
      i_r <= i_r + CW'(1);
      j_r <= j_r - CW'(1);
    end else if (cmd.cnt_init) begin
      i_r <= '0;
    end else if (cmd.cnt_step) begin
      i_r <= i_r + CW'(1);
    end else if (cmd.verdict) begin
      j_r <= jsum[CW-1:0];
    end else if (cmd.copy) begin
      j_r <= j_r + CW'(1);
    end
    if (cmd.cnt_init) cnt_r <= '0;
    else if (cmd.cnt_step) cnt_r <= cnt_r + CW'(alive_r[IW'(i_r)]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_r <= '0;
      pop_r   <= '0;
      copy_r  <= '0;
      ref_r   <= '0;
    end else begin
      if (cmd.do_load && ({1'b0, in_slot} < cap)) alive_r[IW'(in_slot)] <= 1'b1;
      if (cmd.verdict && offs_r == '0) alive_r[IW'(slot_r)] <= 1'b0;
      if (cmd.copy) begin
        alive_r[IW'(j_r)] <= 1'b1;
        copy_r            <= copy_r + CW'(1);
      end
      if (cmd.move) begin
        alive_r[IW'(i_r)] <= 1'b1;
        alive_r[IW'(j_r)] <= 1'b0;
      end
      if (cmd.gen_done) begin
        pop_r  <= cnt_r;
        copy_r <= '0;
        ref_r  <= energy_r;
      end
    end
  end

  // result register
  logic               ovalid_r;
  logic [1:0]         kind_r;
  logic [5:0]         src_r, dst_r;
  logic signed [31:0] oen_r;
  logic [19:0]        owt_r;
  logic signed [35:0] owe_r;
  logic [3:0]         oofs_r;
  logic [6:0]         opop_r;
  logic               olast_r;
  logic               emit;

  assign emit = cmd.verdict | cmd.copy | cmd.move | cmd.gen_done;

  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else if (emit) ovalid_r <= 1'b1;
    else if (out_ch.ready) ovalid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      src_r   <= '0;
      dst_r   <= '0;
      oen_r   <= '0;
      owt_r   <= '0;
      owe_r   <= '0;
      oofs_r  <= '0;
      opop_r  <= pop_r;
      olast_r <= cmd.last;
      if (cmd.verdict) begin
        kind_r <= KIND_VERDICT;
        src_r  <= slot_r;
        oen_r  <= clamped_r;
        owt_r  <= wcap_r;
        owe_r  <= we_r;
        oofs_r <= 4'(offs_r);
      end else if (cmd.copy) begin
        kind_r <= KIND_COPY;
        src_r  <= slot_r;
        dst_r  <= 6'(j_r);
        oen_r  <= clamped_r;
      end else if (cmd.move) begin
        kind_r <= KIND_MOVE;
        src_r  <= 6'(j_r);
        dst_r  <= 6'(i_r);
        oen_r  <= rdata_r;
      end else begin
        kind_r <= KIND_DONE;
        opop_r <= cnt_r;
      end
    end
  end

  assign out_ch.valid           = ovalid_r;
  assign out_ch.kind            = kind_r;
  assign out_ch.source_slot     = src_r;
  assign out_ch.dest_slot       = dst_r;
  assign out_ch.clamped_energy  = oen_r;
  assign out_ch.weight          = owt_r;
  assign out_ch.weighted_energy = owe_r;
  assign out_ch.offspring       = oofs_r;
  assign out_ch.population      = opop_r;
  assign out_ch.last            = olast_r;

  always_comb begin
    sts.func     = in_func;
    sts.walk_ok  = ({1'b0, in_slot} < cap) && ({1'b0, in_slot} < pop_r)
                   && alive_r[IW'(in_slot)];
    sts.out_free = !ovalid_r || out_ch.ready;
    sts.ncopy    = (want < avail) ? want : avail;
    sts.i_lt_j   = (i_r < j_r);
    sts.alive_i  = alive_r[IW'(i_r)];
    sts.alive_j  = alive_r[IW'(j_r)];
    sts.i_ge_cap = (i_r >= cap);
  end

endmodule

`default_nettype wire

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// Walker branching population control testbench
// Drives load, walker and end-of-generation beats through the valid/ready
// input channel, predicts every verdict, copy, move and done beat in a
// scoreboard, and checks the result channel field by field under random
// stalls on both sides and several register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import wbpc_pkg::*;

  localparam int POOL_SLOTS  = 64;
  localparam int OFFSPR_MAX  = 10;
  localparam int SETTLE_CYC  = 400;
  localparam int HOLD_CYC    = 400;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [5:0]         src;
    logic [5:0]         dst;
    logic signed [31:0] energy;
    logic [19:0]        weight;
    logic signed [35:0] wenergy;
    logic [3:0]         offspring;
    logic [6:0]         pop;
    logic               last;
  } branch_beat_t;

  class branch_scoreboard;
    bit                 alive[POOL_SLOTS];
    logic signed [31:0] old_e[POOL_SLOTS];
    int                 pop;
    int                 copies;
    logic signed [31:0] ref_e;
    int unsigned        dt;
    longint             trial;
    longint             half;
    int                 cap_reg;
    branch_beat_t       pending[$];
    int                 errors;
    int                 n_verdicts, n_copies, n_moves, n_kills, n_gens, n_beats;

    function new();
      foreach (alive[i]) begin
        alive[i] = 0;
        old_e[i] = '0;
      end
      pop = 0;
      copies = 0;
      ref_e = '0;
      dt = RST_TIME_STEP;
      trial = 0;
      half = RST_HALFWIDTH;
      cap_reg = RST_CAPACITY;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        REG_TIME_STEP: dt = v[15:0];
        REG_TRIAL:     trial = longint'($signed(v));
        REG_HALFWIDTH: half = v[30:0];
        REG_CAPACITY:  cap_reg = v[6:0];
        default: ;
      endcase
    endfunction

    function int eff_cap();
      return cap_reg > POOL_SLOTS ? POOL_SLOTS : cap_reg;
    endfunction

    function longint exp_weight(longint y);
      longint t, n, f, p, m;
      if (y < -(longint'(16) <<< 16)) y = -(longint'(16) <<< 16);
      if (y > (longint'(4) <<< 16)) y = longint'(4) <<< 16;
      t = (y * longint'(LOG2E_Q16)) >>> 16;
      n = t >>> 16;
      f = t & 65535;
      p = longint'(EXP_C3);
      p = longint'(EXP_C2) + ((p * f) >> 16);
      p = longint'(EXP_C1) + ((p * f) >> 16);
      m = longint'(EXP_C0) + ((p * f) >> 16);
      if (n >= 0) return m << n;
      return m >> (-n);
    endfunction

    function void push(logic [1:0] kind, int src, int dst, longint en, longint wt,
                       longint we, int offs);
      branch_beat_t b;
      b.kind = kind;
      b.src = 6'(src);
      b.dst = 6'(dst);
      b.energy = 32'(en);
      b.weight = 20'(wt);
      b.wenergy = 36'(we);
      b.offspring = 4'(offs);
      b.pop = 7'(pop);
      b.last = 0;
      pending.push_back(b);
    endfunction

    function bit note_item(logic [1:0] func, logic [5:0] slot, logic signed [31:0] energy,
                           logic [15:0] uni);
      int cap, i, j, cnt;
      longint e, d, arg, w, wcap, offs, lo, hi, clamped, we;
      cap = eff_cap();
      e = longint'(energy);
      if (func == FUNC_LOAD) begin
        if (slot >= cap) return 0;
        alive[slot] = 1;
        old_e[slot] = energy;
        return 1;
      end
      if (func == FUNC_WALK) begin
        if (slot >= cap || slot >= pop || !alive[slot]) return 0;
        d = e + longint'(old_e[slot]) - 2 * longint'(ref_e);
        arg = (longint'(dt) * d) >>> 17;
        w = exp_weight(-arg);
        offs = (w + longint'(uni)) >> 16;
        if (offs > OFFSPR_MAX) offs = OFFSPR_MAX;
        lo = trial - half;
        hi = trial + half;
        if (lo < -(longint'(1) <<< 31)) lo = -(longint'(1) <<< 31);
        if (hi > (longint'(1) <<< 31) - 1) hi = (longint'(1) <<< 31) - 1;
        clamped = e;
        if (e < lo) begin
          clamped = lo;
          offs = 0;
        end else if (e > hi) begin
          clamped = hi;
          offs = 0;
        end
        wcap = w > longint'(WEIGHT_CAP) ? longint'(WEIGHT_CAP) : w;
        we = (wcap * clamped) >>> 16;
        if (offs == 0) begin
          alive[slot] = 0;
          n_kills++;
        end
        push(KIND_VERDICT, slot, 0, clamped, wcap, we, int'(offs));
        n_verdicts++;
        j = pop + copies;
        while (offs > 1) begin
          if (j < cap) begin
            old_e[j] = 32'(clamped);
            alive[j] = 1;
            copies = (copies + 1) & 127;
            push(KIND_COPY, slot, j, clamped, 0, 0, 0);
            n_copies++;
            j++;
          end
          offs--;
        end
        old_e[slot] = 32'(clamped);
        pending[$].last = 1;
        return 1;
      end
      if (func == FUNC_GEN) begin
        i = 0;
        if (cap > 0) begin
          j = cap - 1;
          while (i < j) begin
            if (!alive[i]) begin
              while (j > i && !alive[j]) j--;
              if (i >= j) break;
              alive[i] = 1;
              alive[j] = 0;
              old_e[i] = old_e[j];
              push(KIND_MOVE, j, i, old_e[i], 0, 0, 0);
              n_moves++;
              j--;
            end
            i++;
          end
        end
        cnt = 0;
        for (i = 0; i < cap; i++) if (alive[i]) cnt++;
        pop = cnt;
        copies = 0;
        ref_e = energy;
        push(KIND_DONE, 0, 0, 0, 0, 0, 0);
        pending[$].last = 1;
        n_gens++;
        return 1;
      end
      return 0;
    endfunction

    function void cmp(string field, longint expv, longint actv);
      if (expv != actv) begin
        $display("%0t: %s expected %0d actual %0d", $time, field, expv, actv);
        errors++;
      end
    endfunction

    function void check_result(branch_beat_t got);
      branch_beat_t e;
      n_beats++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat kind %0d expected none actual %h", $time,
                 got.kind, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp("kind", e.kind, got.kind);
      cmp("source_slot", e.src, got.src);
      cmp("dest_slot", e.dst, got.dst);
      cmp("clamped_energy", e.energy, got.energy);
      cmp("weight", e.weight, got.weight);
      cmp("weighted_energy", e.wenergy, got.wenergy);
      cmp("offspring", e.offspring, got.offspring);
      cmp("population", e.pop, got.pop);
      cmp("last", e.last, got.last);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  wbpc_in_if  in_bus();
  wbpc_out_if out_bus();

  walker_branching_population_control_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_bus),
    .out_ch    (out_bus)
  );

  branch_scoreboard sb;
  bit               calm;
  bit               hold_off;
  int               items_done;

  always #5 clk = ~clk;

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic cfg_write(logic [1:0] idx, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic send_beat(logic [1:0] f, logic [5:0] s, logic signed [31:0] e,
                           logic [15:0] u);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.func <= f;
    in_bus.slot <= s;
    in_bus.energy <= e;
    in_bus.uniform <= u;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    void'(sb.note_item(f, s, e, u));
    items_done++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  function automatic logic signed [31:0] near(longint base, longint spread);
    if ($urandom_range(0, 9) == 0) return $urandom;
    return 32'(base + longint'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  task automatic run_generation(longint base, longint spread, int upto);
    int nload, n;
    calm = ($urandom_range(0, 3) == 0);
    nload = sb.pop < 4 ? $urandom_range(1, 8) : $urandom_range(0, 2);
    repeat (nload)
      send_beat(FUNC_LOAD, 6'($urandom_range(0, sb.eff_cap() - 1)), near(base, spread),
                16'($urandom));
    send_beat(FUNC_GEN, 0, 32'(base), 16'($urandom));
    n = sb.pop;
    for (int i = 0; i < n; i++) begin
      if (items_done >= upto) break;
      case ($urandom_range(0, 14))
        0: send_beat(FUNC_UNUSED, 6'($urandom), $urandom, 16'($urandom));
        1: send_beat(FUNC_WALK, 6'($urandom), near(base, spread), 16'($urandom));
        2: send_beat(FUNC_LOAD, 6'($urandom), near(base, spread), 16'($urandom));
        default: send_beat(FUNC_WALK, 6'(i), near(base, spread), 16'($urandom));
      endcase
    end
    send_beat(FUNC_GEN, 0, 32'(base + longint'($urandom_range(0, 131072)) - 65536),
              16'($urandom));
  endtask

  task automatic run_phase(int upto);
    longint spread, base;
    spread = (longint'(3) <<< 32) / sb.dt;
    if (spread > (longint'(1) <<< 28)) spread = longint'(1) <<< 28;
    while (items_done < upto) begin
      base = longint'($urandom_range(0, 1 << 30)) - (longint'(1) <<< 29);
      run_generation(base, spread, upto);
    end
  endtask

  initial begin
    #40000000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    branch_beat_t r;
    int stall;
    out_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_off) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYC) @(negedge clk);
        hold_off = 0;
      end
      stall = draw_gap();
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk);
      while (!out_bus.valid) @(posedge clk);
      r.kind = out_bus.kind;
      r.src = out_bus.source_slot;
      r.dst = out_bus.dest_slot;
      r.energy = out_bus.clamped_energy;
      r.weight = out_bus.weight;
      r.wenergy = out_bus.weighted_energy;
      r.offspring = out_bus.offspring;
      r.pop = out_bus.population;
      r.last = out_bus.last;
      sb.check_result(r);
      @(negedge clk);
    end
  end

  initial begin
    sb = new();
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_TIME_STEP;
    cfg_data = '0;
    in_bus.valid = 1'b0;
    in_bus.func = FUNC_LOAD;
    in_bus.slot = '0;
    in_bus.energy = '0;
    in_bus.uniform = '0;
    calm = 0;
    hold_off = 0;
    items_done = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_beat(FUNC_LOAD, 0, 0, 0);
    send_beat(FUNC_LOAD, 1, 3 <<< 16, 16'hFFFF);
    send_beat(FUNC_LOAD, 2, -(3 <<< 16), 0);
    send_beat(FUNC_LOAD, 3, 5 <<< 16, 0);
    send_beat(FUNC_GEN, 0, 0, 0);
    send_beat(FUNC_WALK, 0, 0, 0);
    send_beat(FUNC_WALK, 1, -(19 <<< 16), 16'hFFFF);
    send_beat(FUNC_WALK, 2, 32'sh80000000, 0);
    send_beat(FUNC_WALK, 3, 32'sh7FFFFFFF, 16'hFFFF);
    send_beat(FUNC_WALK, 2, 0, 0);
    send_beat(FUNC_WALK, 40, 0, 0);
    send_beat(FUNC_UNUSED, 6'h3F, 32'shFFFFFFFF, 16'hFFFF);
    send_beat(FUNC_LOAD, 63, -1, 0);
    send_beat(FUNC_GEN, 0, 1 <<< 16, 0);
    send_beat(FUNC_WALK, 0, 0, 16'h8000);
    send_beat(FUNC_GEN, 0, 0, 0);
    run_phase(60);
    drain();

    cfg_write(REG_TIME_STEP, 32'd65535);
    cfg_write(REG_TRIAL, 32'd0);
    cfg_write(REG_HALFWIDTH, 32'd2 << 16);
    cfg_write(REG_CAPACITY, 32'd64);
    hold_off = 1;
    send_beat(FUNC_WALK, 0, -(32'sd8 <<< 16), 16'hFFFF);
    run_phase(130);
    drain();

    cfg_write(REG_TIME_STEP, 32'd1);
    cfg_write(REG_HALFWIDTH, 32'd0);
    cfg_write(REG_CAPACITY, 32'd1);
    send_beat(FUNC_LOAD, 5, 0, 0);
    send_beat(FUNC_LOAD, 0, 0, 0);
    send_beat(FUNC_GEN, 0, 0, 0);
    send_beat(FUNC_WALK, 0, 0, 16'hFFFF);
    run_phase(170);
    drain();

    cfg_write(REG_TIME_STEP, $urandom_range(1, 65535));
    cfg_write(REG_TRIAL, 32'h80000000);
    cfg_write(REG_HALFWIDTH, 32'h7FFFFFFF);
    cfg_write(REG_CAPACITY, 32'd64);
    run_phase(240);
    drain();

    cfg_write(REG_TIME_STEP, $urandom_range(1, 65535));
    cfg_write(REG_TRIAL, 32'h7FFFFFFF);
    cfg_write(REG_CAPACITY, 32'd17);
    run_phase(310);
    drain();

    $display("Covered %0d input beats over five register settings, %0d generations.",
             items_done, sb.n_gens);
    $display("Checked %0d result beats: %0d verdicts, %0d kills, %0d copies, %0d moves.",
             sb.n_beats, sb.n_verdicts, sb.n_kills, sb.n_copies, sb.n_moves);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
